FILE: design/colon_framed_command_parser_unit_assert.svh
// Assertion macros shared by the command parser RTL.
`ifndef COLON_FRAMED_COMMAND_PARSER_UNIT_ASSERT_SVH
`define COLON_FRAMED_COMMAND_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFCP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cfcp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CFCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cfcp assertion failed");

`endif

FILE: design/cfcp_pkg.sv
// Shared types, character codes and constants of the command parser.
`default_nettype none
package cfcp_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int CNT_W         = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_CAPACITY - 1);

    localparam int BYTE_W = 8;
    localparam int VAL_W  = 32;
    localparam int TICK_W = 27;
    localparam int EV_W   = 3;
    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(2000);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_IDX_TICK = '0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int MS_DIVISOR = 1000;
    localparam int DIV_SHIFT  = 38;
    localparam int MAGIC_W    = 29;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC =
        MAGIC_W'(((64'd1 << DIV_SHIFT) + MS_DIVISOR - 1) / MS_DIVISOR);
    localparam int SCALED_W = VAL_W + MAGIC_W;

    localparam logic [BYTE_W-1:0] CHR_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CHR_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CHR_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CHR_VT      = 8'h0B;
    localparam logic [BYTE_W-1:0] CHR_FF      = 8'h0C;
    localparam logic [BYTE_W-1:0] CHR_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CHR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CHR_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CHR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CHR_COLON   = 8'h3A;
    localparam logic [BYTE_W-1:0] CHR_CMD_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CHR_CMD_P   = 8'h50;
    localparam logic [BYTE_W-1:0] CHR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_DIFF   = 8'h20;

    typedef enum logic [EV_W-1:0] {
        EV_NONE    = 3'd0,
        EV_PERIOD  = 3'd1,
        EV_A_ON    = 3'd2,
        EV_A_OFF   = 3'd3,
        EV_UNKNOWN = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_SPACE = 3'd1,
        PH_SIGN  = 3'd2,
        PH_DIGIT = 3'd3,
        PH_DONE  = 3'd4
    } t_phase;

    typedef struct packed {
        t_event             ev;
        logic [BYTE_W-1:0]  letter;
        logic [VAL_W-1:0]   value;
        logic               analog;
    } t_job;

endpackage
`default_nettype wire

FILE: design/cfcp_front.sv
// Front end: assembles lines byte by byte, parses the number and issues commands.
`default_nettype none
module cfcp_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_byte_vld,
    input  wire logic [cfcp_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                           o_job_push,
    output cfcp_pkg::t_job                 o_job
);
    import cfcp_pkg::*;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0] r_first, n_first;
    t_phase            r_phase, n_phase;
    logic [VAL_W-1:0]  r_mag, n_mag;
    logic              r_minus, n_minus;
    logic              r_ovf, n_ovf;
    logic              r_analog, n_analog;

    logic              w_colon, w_eol, w_store, w_nul;
    logic              w_digit, w_space, w_sign, w_take;
    logic [VAL_W+3:0]  w_next_mag;
    logic [VAL_W-1:0]  w_final;
    logic [BYTE_W-1:0] w_upper;

    assign w_colon = (i_rx_byte == CHR_COLON);
    assign w_eol   = (i_rx_byte == CHR_CR) || (i_rx_byte == CHR_LF);
    assign w_store = i_byte_vld && !w_colon && !w_eol && (r_count != CNT_MAX);
    assign w_nul   = (i_rx_byte == CHR_NUL);
    assign w_digit = (i_rx_byte >= CHR_ZERO) && (i_rx_byte <= CHR_NINE);
    assign w_space = (i_rx_byte == CHR_SPACE) || (i_rx_byte == CHR_TAB) ||
                     (i_rx_byte == CHR_VT) || (i_rx_byte == CHR_FF);
    assign w_sign  = (i_rx_byte == CHR_PLUS) || (i_rx_byte == CHR_MINUS);
    assign w_upper = ((i_rx_byte >= CHR_LOWER_A) && (i_rx_byte <= CHR_LOWER_Z)) ?
                     (i_rx_byte - CASE_DIFF) : i_rx_byte;
    assign w_take  = w_store && !w_nul && w_digit &&
                     ((r_phase == PH_SPACE) || (r_phase == PH_SIGN) || (r_phase == PH_DIGIT));
    assign w_next_mag = ({4'd0, r_mag} << 3) + ({4'd0, r_mag} << 1) +
                        (VAL_W + 4)'(i_rx_byte[3:0]);
    assign w_final = r_ovf ? '1 : (r_minus ? (32'd0 - r_mag) : r_mag);

    always_comb begin
        n_phase = r_phase;
        if (i_byte_vld && (w_colon || w_eol)) begin
            n_phase = PH_FIRST;
        end else if (w_store) begin
            if (r_phase == PH_FIRST) begin
                n_phase = w_nul ? PH_DONE : PH_SPACE;
            end else if (w_nul) begin
                n_phase = PH_DONE;
            end else begin
                case (r_phase)
                    PH_SPACE: begin
                        if (w_space) begin
                            n_phase = PH_SPACE;
                        end else if (w_sign) begin
                            n_phase = PH_SIGN;
                        end else if (w_digit) begin
                            n_phase = PH_DIGIT;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_SIGN, PH_DIGIT: begin
                        n_phase = w_digit ? PH_DIGIT : PH_DONE;
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    always_comb begin
        n_count    = r_count;
        n_first    = r_first;
        n_mag      = r_mag;
        n_minus    = r_minus;
        n_ovf      = r_ovf;
        n_analog   = r_analog;
        o_job_push = 1'b0;
        o_job      = '{ev: EV_NONE, letter: '0, value: '0, analog: 1'b0};

        if (w_store) begin
            n_count = r_count + 1'b1;
            if (r_phase == PH_FIRST) begin
                n_first = w_upper;
            end
            if (w_store && !w_nul && (r_phase == PH_SPACE) && w_sign) begin
                n_minus = (i_rx_byte == CHR_MINUS);
            end
            if (w_take) begin
                if (r_ovf || (w_next_mag[VAL_W+3:VAL_W] != 4'd0)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_mag = w_next_mag[VAL_W-1:0];
                end
            end
        end

        if (i_byte_vld && (w_colon || w_eol)) begin
            n_count = '0;
            n_first = '0;
            n_mag   = '0;
            n_minus = 1'b0;
            n_ovf   = 1'b0;
        end

        if (i_byte_vld && w_eol) begin
            if (r_analog) begin
                n_analog   = 1'b0;
                o_job_push = 1'b1;
                o_job.ev   = EV_A_OFF;
            end else if (r_count != '0) begin
                o_job_push = 1'b1;
                if (r_first != CHR_NUL) begin
                    o_job.letter = r_first;
                    o_job.value  = w_final;
                    if (r_first == CHR_CMD_P) begin
                        o_job.ev = EV_PERIOD;
                    end else if (r_first == CHR_CMD_A) begin
                        n_analog     = (w_final == 32'd1);
                        o_job.ev     = n_analog ? EV_A_ON : EV_A_OFF;
                        o_job.analog = n_analog;
                    end else begin
                        o_job.ev = EV_UNKNOWN;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_first  <= '0;
            r_phase  <= PH_FIRST;
            r_mag    <= '0;
            r_minus  <= 1'b0;
            r_ovf    <= 1'b0;
            r_analog <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_first  <= n_first;
            r_phase  <= n_phase;
            r_mag    <= n_mag;
            r_minus  <= n_minus;
            r_ovf    <= n_ovf;
            r_analog <= n_analog;
        end
    end

endmodule
`default_nettype wire

FILE: design/cfcp_queue.sv
// Short command queue between the front end and the execution pipeline.
`default_nettype none
module cfcp_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  cfcp_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  wire logic     i_pop,
    output cfcp_pkg::t_job o_job
);
    import cfcp_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_do_push, w_do_pop;

    assign o_full    = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_job     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: design/cfcp_back.sv
// Execution pipeline: computes the timer reload and holds the result register.
`default_nettype none
module cfcp_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [cfcp_pkg::TICK_W-1:0] i_tick_hz,
    input  wire logic                        i_job_vld,
    input  cfcp_pkg::t_job                   i_job,
    output logic                             o_job_pop,
    output logic                             o_res_vld,
    input  wire logic                        i_res_pop,
    output cfcp_pkg::t_job                   o_res_job,
    output logic [cfcp_pkg::VAL_W-1:0]       o_res_reload
);
    import cfcp_pkg::*;

    logic                r1_vld, r2_vld, r3_vld;
    t_job                r1_job, r2_job, r3_job;
    logic [VAL_W-1:0]    r1_prod;
    logic [SCALED_W-1:0] r2_scaled;
    logic [VAL_W-1:0]    r3_reload;

    logic                w_rdy1, w_rdy2, w_rdy3;
    logic [VAL_W-1:0]    w_ms, w_prod, w_quot, w_reload;
    logic [SCALED_W-1:0] w_scaled;

    assign w_rdy3    = !r3_vld || i_res_pop;
    assign w_rdy2    = !r2_vld || w_rdy3;
    assign w_rdy1    = !r1_vld || w_rdy2;
    assign o_job_pop = i_job_vld && w_rdy1;

    assign w_ms     = (i_job.value == '0) ? VAL_W'(1) : i_job.value;
    assign w_prod   = {{(VAL_W - TICK_W){1'b0}}, i_tick_hz} * w_ms;
    assign w_scaled = {{MAGIC_W{1'b0}}, r1_prod} * {{VAL_W{1'b0}}, DIV_MAGIC};
    assign w_quot   = VAL_W'(r2_scaled >> DIV_SHIFT);
    assign w_reload = (r2_job.ev != EV_PERIOD) ? '0 :
                      ((w_quot == '0) ? '0 : (w_quot - 1'b1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r1_vld <= i_job_vld;
            end
            if (w_rdy2) begin
                r2_vld <= r1_vld;
            end
            if (w_rdy3) begin
                r3_vld <= r2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_job_vld) begin
            r1_job  <= i_job;
            r1_prod <= w_prod;
        end
        if (w_rdy2 && r1_vld) begin
            r2_job    <= r1_job;
            r2_scaled <= w_scaled;
        end
        if (w_rdy3 && r2_vld) begin
            r3_job    <= r2_job;
            r3_reload <= w_reload;
        end
    end

    assign o_res_vld    = r3_vld;
    assign o_res_job    = r3_job;
    assign o_res_reload = r3_reload;

endmodule
`default_nettype wire

FILE: design/colon_framed_command_parser_unit.sv
// Top level of the colon-framed serial command parser.
// One received byte is accepted per clock cycle while full is low. Bytes are
// parsed as they arrive; a CR or LF that ends a non-empty line, or that leaves
// analog mode, puts one result on the result ports after a two-entry command
// queue and a three-stage execution pipeline (tick product, reciprocal multiply
// for the divide by 1000, clamp). full rises only when the queue and the
// pipeline are both backed up behind an unread result.
// The tick rate register sits at byte address 0 and must be written while no
// line end is in flight.
`default_nettype none
`include "colon_framed_command_parser_unit_assert.svh"
module colon_framed_command_parser_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [cfcp_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [cfcp_pkg::EV_W-1:0]        o_event_res,
    output logic [cfcp_pkg::BYTE_W-1:0]      o_command_letter,
    output logic [cfcp_pkg::VAL_W-1:0]       o_parsed_value,
    output logic [cfcp_pkg::VAL_W-1:0]       o_timer_reload,
    output logic                             o_analog_on,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cfcp_pkg::APB_AW-1:0] paddr,
    input  wire logic [cfcp_pkg::APB_DW-1:0] pwdata,
    output logic [cfcp_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import cfcp_pkg::*;

    logic [TICK_W-1:0] r_tick_hz;
    logic              w_accept, w_cfg_wr, w_sel_tick;
    logic              w_job_push, w_q_valid, w_q_pop, w_res_vld;
    t_job              w_job, w_q_job, w_res_job;
    logic [VAL_W-1:0]  w_res_reload;

    assign pready     = 1'b1;
    assign w_sel_tick = (paddr[APB_AW-1:2] == REG_IDX_TICK);
    assign w_cfg_wr   = psel && penable && pwrite && pready && w_sel_tick;
    assign prdata     = (psel && w_sel_tick) ? {{(APB_DW - TICK_W){1'b0}}, r_tick_hz} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_hz <= TICK_RESET;
        end else if (w_cfg_wr) begin
            r_tick_hz <= pwdata[TICK_W-1:0];
        end
    end

    assign w_accept = push && !full;

    cfcp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (w_accept),
        .i_rx_byte  (i_rx_byte),
        .o_job_push (w_job_push),
        .o_job      (w_job)
    );

    cfcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job),
        .o_full  (full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_job   (w_q_job)
    );

    cfcp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_hz    (r_tick_hz),
        .i_job_vld    (w_q_valid),
        .i_job        (w_q_job),
        .o_job_pop    (w_q_pop),
        .o_res_vld    (w_res_vld),
        .i_res_pop    (pop),
        .o_res_job    (w_res_job),
        .o_res_reload (w_res_reload)
    );

    assign empty            = !w_res_vld;
    assign o_event_res      = w_res_job.ev;
    assign o_command_letter = w_res_job.letter;
    assign o_parsed_value   = w_res_job.value;
    assign o_timer_reload   = w_res_reload;
    assign o_analog_on      = w_res_job.analog;

    `CFCP_ASSERT_IMP(a_analog_on_flag, !empty && (o_event_res == EV_A_ON), o_analog_on)
    `CFCP_ASSERT_IMP(a_reload_only_period, !empty && (o_event_res != EV_PERIOD), o_timer_reload == '0)
    `CFCP_ASSERT_IMP(a_push_only_eol, w_job_push, w_accept && ((i_rx_byte == CHR_CR) || (i_rx_byte == CHR_LF)))
    `CFCP_ASSERT_NEXT(a_push_reaches_queue, w_job_push, w_q_valid)

endmodule
`default_nettype wire
